@@ hw/rtl/rtu_crc_pkg.sv @@
// ----------------------------------------------------------------------------
// rtu_crc_pkg
// Shared types, codes and the CRC-16 byte update for the RTU frame engine.
// ----------------------------------------------------------------------------
package rtu_crc_pkg;

  // Register indexes on the configuration port
  localparam logic REG_SLAVE_ADDRESS = 1'b0;
  localparam logic REG_FRAME_LIMIT   = 1'b1;

  // Reset values of the registers
  localparam logic [7:0] SLAVE_ADDRESS_RESET = 8'd104;
  localparam logic [8:0] FRAME_LIMIT_RESET   = 9'd64;

  // CRC-16 (reflected form)
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Byte counter saturation and smallest valid response
  localparam logic [8:0] CNT_MAX       = 9'd511;
  localparam logic [8:0] MIN_RESP_LEN  = 9'd5;

  // Result queue depth; one item may push up to three results
  localparam int QDEPTH   = 4;
  localparam int QCOUNT_W = $clog2(QDEPTH + 1);
  localparam int MAX_PUSH = 3;

  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_FRAME_ERR = 3'd1,
    STATUS_CRC_ERR   = 3'd2,
    STATUS_EXCEPTION = 3'd3,
    STATUS_TOO_LONG  = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    status_t    status;
    logic       status_valid;
    logic [8:0] frame_length;
    logic       end_of_run;
  } result_t;

  // One byte through the CRC: eight shift/xor steps
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/modbus_rtu_frame_crc_engine.sv @@
// ----------------------------------------------------------------------------
// modbus_rtu_frame_crc_engine
// Modbus RTU byte framer: echoes request bytes and appends the CRC-16 unless the
// frame is too long, or checks response bytes and reports one status per frame.
// ----------------------------------------------------------------------------
// A result is registered into the result queue when its item is accepted.
// Throughput: one item per cycle while results drain at one per cycle; a last
//   request byte within frame_limit yields three results, so the output port sets the pace then.
// The four-entry result queue stalls the input while it holds two or more.
// Reset (rst, synchronous): empties the queue, clears the frame state and
//   loads slave_address 104 and frame_limit 64.
module modbus_rtu_frame_crc_engine
  import rtu_crc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // configuration write port
  input  logic       cfg_write,
  input  logic       cfg_index,
  input  logic [8:0] cfg_data,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       func,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  // output channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic [2:0] status,
  output logic       status_valid,
  output logic [8:0] frame_length,
  output logic       end_of_run
);

  localparam logic [QCOUNT_W-1:0] STALL_LEVEL = QCOUNT_W'(QDEPTH - MAX_PUSH + 1);

  // Configuration registers
  logic [7:0] slave_address;
  logic [8:0] frame_limit;

  // Frame state
  logic [15:0] running_crc,     running_crc_next;
  logic [8:0]  byte_count,      byte_count_next;
  logic [7:0]  held_byte_older, held_byte_older_next;
  logic [7:0]  held_byte_newer, held_byte_newer_next;
  logic        address_matched, address_matched_next;
  logic        exception_seen,  exception_seen_next;

  // Result queue, head at entry 0
  result_t               queue [QDEPTH];
  result_t               queue_next [QDEPTH];
  logic [QCOUNT_W-1:0]   count, count_next;

  // Results produced by the current item
  result_t               res [MAX_PUSH];
  logic [1:0]            npush;

  logic        accept;
  logic        pop;
  logic [8:0]  n;
  logic [9:0]  total_wide;
  logic [8:0]  total;
  logic [15:0] crc_upd;
  logic [15:0] got;
  status_t     st;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (count >= STALL_LEVEL);
  assign out_valid = (count != '0);
  assign pop       = out_valid && !out_stall;

  // Drive the output port from the queue head
  assign out_byte     = queue[0].out_byte;
  assign byte_valid   = queue[0].byte_valid;
  assign status       = queue[0].status;
  assign status_valid = queue[0].status_valid;
  assign frame_length = queue[0].frame_length;
  assign end_of_run   = queue[0].end_of_run;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= SLAVE_ADDRESS_RESET;
      frame_limit   <= FRAME_LIMIT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SLAVE_ADDRESS: slave_address <= cfg_data[7:0];
        REG_FRAME_LIMIT:   frame_limit   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Process one byte: frame state update and its results
  always_comb begin
    n          = (byte_count == CNT_MAX) ? CNT_MAX : byte_count + 9'd1;
    crc_upd    = crc_byte(running_crc, func ? data_byte : held_byte_older);
    total_wide = {1'b0, n} + 10'd2;
    total      = (total_wide > {1'b0, CNT_MAX}) ? CNT_MAX : total_wide[8:0];

    running_crc_next     = running_crc;
    byte_count_next      = byte_count;
    held_byte_older_next = held_byte_older;
    held_byte_newer_next = held_byte_newer;
    address_matched_next = address_matched;
    exception_seen_next  = exception_seen;
    got                  = {data_byte, held_byte_newer};
    st                   = STATUS_OK;
    npush                = 2'd0;
    for (int i = 0; i < MAX_PUSH; i++) begin
      res[i] = '0;
    end

    if (accept) begin
      if (func) begin
        // send: echo, then CRC low and high after a last byte within frame_limit
        running_crc_next = crc_upd;
        byte_count_next  = n;
        res[0].out_byte   = data_byte;
        res[0].byte_valid = 1'b1;
        npush             = 2'd1;
        if (!last_byte) begin
          res[0].end_of_run = 1'b1;
        end else if (total > frame_limit) begin
          res[0].status       = STATUS_TOO_LONG;
          res[0].status_valid = 1'b1;
          res[0].frame_length = total;
          res[0].end_of_run   = 1'b1;
        end else begin
          res[1].out_byte     = crc_upd[7:0];
          res[1].byte_valid   = 1'b1;
          res[2].out_byte     = crc_upd[15:8];
          res[2].byte_valid   = 1'b1;
          res[2].status_valid = 1'b1;
          res[2].frame_length = total;
          res[2].end_of_run   = 1'b1;
          npush               = 2'd3;
        end
      end else begin
        // check: hold the last two bytes back from the CRC
        if (byte_count == 9'd0) begin
          address_matched_next = (data_byte == slave_address);
        end
        if (byte_count == 9'd1) begin
          exception_seen_next = data_byte[7];
        end
        if (byte_count >= 9'd2) begin
          running_crc_next = crc_upd;
        end
        held_byte_older_next = held_byte_newer;
        held_byte_newer_next = data_byte;
        byte_count_next      = n;
        if (last_byte) begin
          if (n < MIN_RESP_LEN || !address_matched_next || n > frame_limit) begin
            st = STATUS_FRAME_ERR;
          end else if (running_crc_next != got) begin
            st = STATUS_CRC_ERR;
          end else if (exception_seen_next) begin
            st = STATUS_EXCEPTION;
          end else begin
            st = STATUS_OK;
          end
          res[0].status       = st;
          res[0].status_valid = 1'b1;
          res[0].frame_length = n;
          res[0].end_of_run   = 1'b1;
          npush               = 2'd1;
        end
      end

      // drop the frame state once a frame ends
      if (last_byte) begin
        running_crc_next     = CRC_INIT;
        byte_count_next      = '0;
        held_byte_older_next = '0;
        held_byte_newer_next = '0;
        address_matched_next = 1'b0;
        exception_seen_next  = 1'b0;
      end
    end
  end

  // Queue update: shift on pop, append new results behind the survivors
  always_comb begin
    logic [QCOUNT_W-1:0] base;
    logic [QCOUNT_W-1:0] slot;
    base = count - QCOUNT_W'(pop);
    slot = '0;
    for (int i = 0; i < QDEPTH; i++) begin
      if (pop && i < QDEPTH - 1) begin
        queue_next[i] = queue[i + 1];
      end else begin
        queue_next[i] = queue[i];
      end
      slot = QCOUNT_W'(i) - base;
      if (QCOUNT_W'(i) >= base && slot < QCOUNT_W'(npush)) begin
        queue_next[i] = res[slot[1:0]];
      end
    end
    count_next = base + QCOUNT_W'(npush);
  end

  // Control and frame state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count           <= '0;
      running_crc     <= CRC_INIT;
      byte_count      <= '0;
      held_byte_older <= '0;
      held_byte_newer <= '0;
      address_matched <= 1'b0;
      exception_seen  <= 1'b0;
    end else begin
      count           <= count_next;
      running_crc     <= running_crc_next;
      byte_count      <= byte_count_next;
      held_byte_older <= held_byte_older_next;
      held_byte_newer <= held_byte_newer_next;
      address_matched <= address_matched_next;
      exception_seen  <= exception_seen_next;
    end
  end

  // Result payload, no reset
  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      queue[i] <= queue_next[i];
    end
  end

endmodule

@@ hw/rtl/rtu_crc_checker.sv @@
// ----------------------------------------------------------------------------
// rtu_crc_checker
// Port-level assertions for the RTU frame engine, bound to the top level.
// ----------------------------------------------------------------------------
module rtu_crc_checker
  import rtu_crc_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       byte_valid,
  input logic [2:0] status,
  input logic       status_valid,
  input logic [8:0] frame_length,
  input logic       end_of_run
);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(status)
      && $stable(frame_length) && $stable(end_of_run))
    else $error("stalled result changed");

  // Start empty after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered right after reset");

  // End every frame status on the last result of its item
  a_status_ends_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && status_valid |-> end_of_run)
    else $error("status result does not end its run");

  // Give a result without a byte only as a check status
  a_check_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> status_valid && out_byte == 8'd0
      && status != STATUS_TOO_LONG)
    else $error("byte-less result is not a check status");

  // Report a too-long request only on its echoed byte
  a_too_long: assert property (@(posedge clk) disable iff (rst)
    out_valid && status_valid && status == STATUS_TOO_LONG |-> byte_valid)
    else $error("request-too-long status without echo");

endmodule

bind modbus_rtu_frame_crc_engine rtu_crc_checker u_rtu_crc_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_byte     (out_byte),
  .byte_valid   (byte_valid),
  .status       (status),
  .status_valid (status_valid),
  .frame_length (frame_length),
  .end_of_run   (end_of_run)
);
